FILE: sv/ppbc_pkg.sv
// ----------------------------------------------------------------------------
// ppbc_pkg
// Shared types and constants for the port and protocol byte counter: command
// codes, report codes, header offsets and the per-frame header record.
// ----------------------------------------------------------------------------
`default_nettype none

package ppbc_pkg;

  // Frame layout and counter geometry
  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned CntWidth      = 64;
  localparam int unsigned PortWidth     = 16;
  localparam int unsigned NumPorts      = 1 << PortWidth;
  localparam int unsigned NumProtocols  = 3;

  // IPv4 and transport header constants
  localparam int unsigned IpProtoOffset = 9;
  localparam int unsigned MinIhlBytes   = 20;
  localparam int unsigned TcpOffsetByte = 12;
  localparam int unsigned TcpMinBytes   = 13;
  localparam int unsigned UdpMinBytes   = 4;
  localparam int unsigned MinTcpOffset  = 5;

  localparam logic [7:0]           ProtoTcp       = 8'd6;
  localparam logic [7:0]           ProtoUdp       = 8'd17;
  localparam logic [7:0]           ProtoIcmp      = 8'd1;
  localparam logic [PortWidth-1:0] ThresholdReset = 16'd9999;

  typedef enum logic [1:0] {
    CmdByte      = 2'd0,
    CmdReadProto = 2'd1,
    CmdReadPort  = 2'd2,
    CmdNone      = 2'd3
  } cmd_e;

  typedef enum logic {
    KindFrame = 1'b0,
    KindRead  = 1'b1
  } reply_kind_e;

  typedef enum logic [1:0] {
    ClsTcp   = 2'd0,
    ClsUdp   = 2'd1,
    ClsIcmp  = 2'd2,
    ClsOther = 2'd3
  } proto_class_e;

  typedef enum logic [1:0] {
    StPortCounted = 2'd0,
    StProtoOnly   = 2'd1,
    StBadOffset   = 2'd2,
    StNothing     = 2'd3
  } status_e;

  // Header fields of the frame seen so far, including the current byte
  typedef struct packed {
    logic [15:0]          len;
    logic [5:0]           ihl_bytes;
    logic [7:0]           protocol;
    logic [PortWidth-1:0] source_port;
    logic [PortWidth-1:0] dest_port;
    logic [3:0]           tcp_offset;
  } frame_info_t;

endpackage

`default_nettype wire

FILE: sv/ppbc_frame_parser.sv
// ----------------------------------------------------------------------------
// ppbc_frame_parser
// Follows the byte position within a frame and picks the IPv4 header length,
// protocol, transport ports and TCP data offset out of the byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ppbc_frame_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  byte_en_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_byte_i,
  output ppbc_pkg::frame_info_t      info_o
);

  logic [15:0]                    pos_q;
  logic [5:0]                     ihl_q,   ihl_d;
  logic [7:0]                     proto_q, proto_d;
  logic [ppbc_pkg::PortWidth-1:0] sport_q, sport_d;
  logic [ppbc_pkg::PortWidth-1:0] dport_q, dport_d;
  logic [3:0]                     toff_q,  toff_d;
  logic [15:0]                    len;
  logic [15:0]                    ip_end;
  logic [15:0]                    tp_pos;
  logic                           in_transport;

  // IPv4 header fields at their fixed offsets
  always_comb begin
    ihl_d   = ihl_q;
    proto_d = proto_q;
    if (pos_q == 16'(ppbc_pkg::EthHdrBytes)) begin
      ihl_d = {data_byte_i[3:0], 2'b00};
    end else if (pos_q == 16'(ppbc_pkg::EthHdrBytes + ppbc_pkg::IpProtoOffset)) begin
      proto_d = data_byte_i;
    end
  end

  // Transport header bytes, relative to the end of the IPv4 header
  assign ip_end       = 16'(ppbc_pkg::EthHdrBytes) + 16'(ihl_d);
  assign in_transport = (ihl_d >= 6'(ppbc_pkg::MinIhlBytes)) && (pos_q >= ip_end);
  assign tp_pos       = pos_q - ip_end;

  always_comb begin
    sport_d = sport_q;
    dport_d = dport_q;
    toff_d  = toff_q;
    if (in_transport) begin
      if (tp_pos == 16'd0) begin
        sport_d = {data_byte_i, sport_q[7:0]};
      end else if (tp_pos == 16'd1) begin
        sport_d = {sport_q[15:8], data_byte_i};
      end else if (tp_pos == 16'd2) begin
        dport_d = {data_byte_i, dport_q[7:0]};
      end else if (tp_pos == 16'd3) begin
        dport_d = {dport_q[15:8], data_byte_i};
      end else if (tp_pos == 16'(ppbc_pkg::TcpOffsetByte)) begin
        toff_d = data_byte_i[7:4];
      end
    end
  end

  // Byte count of the frame, saturating
  assign len = (pos_q == '1) ? pos_q : pos_q + 16'd1;

  assign info_o = '{
    len:         len,
    ihl_bytes:   ihl_d,
    protocol:    proto_d,
    source_port: sport_d,
    dest_port:   dport_d,
    tcp_offset:  toff_d
  };

  // Frame state; the last byte starts the next frame afresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ihl_q   <= '0;
      proto_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
      toff_q  <= '0;
    end else if (byte_en_i) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        ihl_q   <= '0;
        proto_q <= '0;
        sport_q <= '0;
        dport_q <= '0;
        toff_q  <= '0;
      end else begin
        pos_q   <= len;
        ihl_q   <= ihl_d;
        proto_q <= proto_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
        toff_q  <= toff_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ppbc_count_ram.sv
// ----------------------------------------------------------------------------
// ppbc_count_ram
// Per-port byte counters: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppbc_count_ram (
  input  wire logic                                clk_i,
  input  wire logic                                wr_en_i,
  input  wire logic [ppbc_pkg::PortWidth-1:0]      wr_addr_i,
  input  wire logic [ppbc_pkg::CntWidth-1:0]       wr_data_i,
  input  wire logic                                rd_en_i,
  input  wire logic [ppbc_pkg::PortWidth-1:0]      rd_addr_i,
  output logic      [ppbc_pkg::CntWidth-1:0]       rd_data_o
);

  logic [ppbc_pkg::CntWidth-1:0] mem_q [ppbc_pkg::NumPorts];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; a read at the address being written returns the old data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/packet_protocol_port_byte_counter.sv
// ----------------------------------------------------------------------------
// packet_protocol_port_byte_counter
// Counts frame bytes per protocol (TCP, UDP, ICMP) and per transport port,
// gives one report per frame and answers counter read commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid_i / in_ready_o  command, data_byte, last_byte,
//                                                wire_length, read_index
//  result    out        out_valid_o / out_ready_i reply_kind, protocol_class,
//                                                status, counted_port, read_value
//  config    in         cfg_wr_en_i              cfg_wr_data_i (port threshold)
//
// One transaction is accepted per cycle while in_ready_o is high. A result passes
// the stage 1 register, which feeds header decode and the port counter RAM read,
// the stage 2 register, which holds the RAM data, and the output register; the
// counter update is written as the result enters it. Bytes that are not a
// frame's last byte, and command 3, give no result. After reset the port counter
// RAM is cleared one entry per cycle, all 65536 entries, during which in_ready_o
// is low. A stalled output holds its result while the stages behind it keep
// filling; once both are full, in_ready_o falls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_protocol_port_byte_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [15:0] cfg_wr_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [15:0] wire_length_i,
  input  wire logic [15:0] read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             reply_kind_o,
  output logic [1:0]       protocol_class_o,
  output logic [1:0]       status_o,
  output logic [15:0]      counted_port_o,
  output logic [63:0]      read_value_o
);

  localparam int unsigned PW = ppbc_pkg::PortWidth;
  localparam int unsigned CW = ppbc_pkg::CntWidth;

  logic [PW-1:0]          threshold_q;
  logic                   clr_busy_q;
  logic [PW-1:0]          clr_addr_q;

  logic                   in_acc;
  logic                   s1_adv, s2_adv, s3_load;
  ppbc_pkg::cmd_e         in_cmd;
  ppbc_pkg::frame_info_t  info;

  // Stage 1: decoded transaction
  logic                   s1_valid_q;
  ppbc_pkg::cmd_e         s1_cmd_q;
  ppbc_pkg::frame_info_t  s1_info_q;
  logic [15:0]            s1_wire_q;
  logic [15:0]            s1_idx_q;

  // Stage 2: counter RAM data available
  logic                       s2_valid_q;
  ppbc_pkg::reply_kind_e      s2_kind_q;
  ppbc_pkg::proto_class_e     s2_class_q;
  ppbc_pkg::status_e          s2_status_q;
  logic [PW-1:0]              s2_port_q;
  logic [PW-1:0]              s2_addr_q;
  logic                       s2_wr_q;
  logic                       s2_rd_port_q;
  logic                       s2_rd_proto_q;
  logic [1:0]                 s2_proto_idx_q;
  logic [15:0]                s2_wire_q;

  // Output register
  logic                       out_valid_q;
  ppbc_pkg::reply_kind_e      out_kind_q;
  ppbc_pkg::proto_class_e     out_class_q;
  ppbc_pkg::status_e          out_status_q;
  logic [PW-1:0]              out_port_q;
  logic [CW-1:0]              out_value_q;

  logic [CW-1:0]              proto_cnt_q [ppbc_pkg::NumProtocols];

  // Write forwarding across the RAM read latency
  logic                       fw_valid_q;
  logic [PW-1:0]              fw_addr_q;
  logic [CW-1:0]              fw_data_q;

  ppbc_pkg::proto_class_e     s1_class;
  ppbc_pkg::status_e          s1_status;
  ppbc_pkg::reply_kind_e      s1_kind;
  logic [PW-1:0]              s1_port;
  logic [PW-1:0]              s1_addr;
  logic [15:0]                s1_ip_end;
  logic                       s1_hdr_ok;
  logic                       s1_frame;

  logic [CW-1:0]              ram_rd_data;
  logic [CW-1:0]              cnt_cur;
  logic [CW-1:0]              cnt_sum;
  logic [CW-1:0]              proto_val;
  logic [CW-1:0]              s2_value;
  logic                       item_wr;
  logic                       ram_wr_en;
  logic [PW-1:0]              ram_wr_addr;
  logic [CW-1:0]              ram_wr_data;

  // Handshake and stage advance
  assign s3_load    = !out_valid_q || out_ready_i;
  assign s2_adv     = !s2_valid_q || s3_load;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv && !clr_busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_cmd     = ppbc_pkg::cmd_e'(command_i);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ppbc_pkg::ThresholdReset;
    end else if (cfg_wr_en_i) begin
      threshold_q <= cfg_wr_data_i;
    end
  end

  // Clearing pass over the port counter RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + PW'(1);
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  ppbc_frame_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (in_acc && (in_cmd == ppbc_pkg::CmdByte)),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .info_o      (info)
  );

  // Stage 1 register: frame ends and read commands only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_acc && (((in_cmd == ppbc_pkg::CmdByte) && last_byte_i) ||
                               (in_cmd == ppbc_pkg::CmdReadProto) ||
                               (in_cmd == ppbc_pkg::CmdReadPort));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_cmd;
      s1_info_q <= info;
      s1_wire_q <= wire_length_i;
      s1_idx_q  <= read_index_i;
    end
  end

  // Frame classification at the last byte
  assign s1_frame  = (s1_cmd_q == ppbc_pkg::CmdByte);
  assign s1_ip_end = 16'(ppbc_pkg::EthHdrBytes) + 16'(s1_info_q.ihl_bytes);
  assign s1_hdr_ok = (s1_info_q.ihl_bytes >= 6'(ppbc_pkg::MinIhlBytes)) &&
                     (s1_info_q.len >= s1_ip_end);

  always_comb begin
    s1_kind   = ppbc_pkg::KindRead;
    s1_class  = ppbc_pkg::ClsOther;
    s1_status = ppbc_pkg::StNothing;
    s1_port   = '0;
    if (s1_frame) begin
      s1_kind = ppbc_pkg::KindFrame;
      if (s1_hdr_ok) begin
        priority if ((s1_info_q.protocol == ppbc_pkg::ProtoTcp) &&
                     (s1_info_q.len >= s1_ip_end + 16'(ppbc_pkg::TcpMinBytes))) begin
          s1_class  = ppbc_pkg::ClsTcp;
          s1_status = (s1_info_q.tcp_offset < 4'(ppbc_pkg::MinTcpOffset)) ?
                      ppbc_pkg::StBadOffset : ppbc_pkg::StPortCounted;
        end else if ((s1_info_q.protocol == ppbc_pkg::ProtoUdp) &&
                     (s1_info_q.len >= s1_ip_end + 16'(ppbc_pkg::UdpMinBytes))) begin
          s1_class  = ppbc_pkg::ClsUdp;
          s1_status = ppbc_pkg::StPortCounted;
        end else if (s1_info_q.protocol == ppbc_pkg::ProtoIcmp) begin
          s1_class  = ppbc_pkg::ClsIcmp;
          s1_status = ppbc_pkg::StProtoOnly;
        end else begin
          s1_class  = ppbc_pkg::ClsOther;
          s1_status = ppbc_pkg::StNothing;
        end
      end
      if (s1_status == ppbc_pkg::StPortCounted) begin
        s1_port = (s1_info_q.dest_port > threshold_q) ? s1_info_q.source_port :
                                                         s1_info_q.dest_port;
      end
    end
  end

  assign s1_addr = (s1_cmd_q == ppbc_pkg::CmdReadPort) ? s1_idx_q : s1_port;

  // Stage 2 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_kind_q      <= s1_kind;
      s2_class_q     <= s1_class;
      s2_status_q    <= s1_status;
      s2_port_q      <= s1_port;
      s2_addr_q      <= s1_addr;
      s2_wr_q        <= s1_frame && (s1_status == ppbc_pkg::StPortCounted);
      s2_rd_port_q   <= (s1_cmd_q == ppbc_pkg::CmdReadPort);
      s2_rd_proto_q  <= (s1_cmd_q == ppbc_pkg::CmdReadProto) &&
                        (s1_idx_q < 16'(ppbc_pkg::NumProtocols));
      s2_proto_idx_q <= s1_idx_q[1:0];
      s2_wire_q      <= s1_wire_q;
    end
  end

  // Counter value with the previous transaction's write forwarded
  assign cnt_cur = (fw_valid_q && (fw_addr_q == s2_addr_q)) ? fw_data_q : ram_rd_data;
  assign cnt_sum = cnt_cur + CW'(s2_wire_q);
  assign item_wr = s3_load && s2_valid_q && s2_wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
    end else if (s2_adv) begin
      fw_valid_q <= item_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      fw_addr_q <= s2_addr_q;
      fw_data_q <= cnt_sum;
    end
  end

  // RAM write port is shared with the clearing pass
  assign ram_wr_en   = clr_busy_q || item_wr;
  assign ram_wr_addr = clr_busy_q ? clr_addr_q : s2_addr_q;
  assign ram_wr_data = clr_busy_q ? '0 : cnt_sum;

  ppbc_count_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (s2_adv && s1_valid_q),
    .rd_addr_i (s1_addr),
    .rd_data_o (ram_rd_data)
  );

  // Protocol counter read
  always_comb begin
    unique case (s2_proto_idx_q)
      2'd0:    proto_val = proto_cnt_q[0];
      2'd1:    proto_val = proto_cnt_q[1];
      2'd2:    proto_val = proto_cnt_q[2];
      default: proto_val = '0;
    endcase
  end

  always_comb begin
    if (s2_rd_port_q) begin
      s2_value = cnt_cur;
    end else if (s2_rd_proto_q) begin
      s2_value = proto_val;
    end else begin
      s2_value = '0;
    end
  end

  // Protocol counters, updated as the frame report leaves stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_cnt_q[0] <= '0;
      proto_cnt_q[1] <= '0;
      proto_cnt_q[2] <= '0;
    end else if (s3_load && s2_valid_q && (s2_kind_q == ppbc_pkg::KindFrame)) begin
      unique case (s2_class_q)
        ppbc_pkg::ClsTcp:  proto_cnt_q[0] <= proto_cnt_q[0] + CW'(s2_wire_q);
        ppbc_pkg::ClsUdp:  proto_cnt_q[1] <= proto_cnt_q[1] + CW'(s2_wire_q);
        ppbc_pkg::ClsIcmp: proto_cnt_q[2] <= proto_cnt_q[2] + CW'(s2_wire_q);
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_load) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load && s2_valid_q) begin
      out_kind_q   <= s2_kind_q;
      out_class_q  <= s2_class_q;
      out_status_q <= s2_status_q;
      out_port_q   <= s2_port_q;
      out_value_q  <= s2_value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reply_kind_o     = out_kind_q;
  assign protocol_class_o = out_class_q;
  assign status_o         = out_status_q;
  assign counted_port_o   = out_port_q;
  assign read_value_o     = out_value_q;

endmodule

`default_nettype wire

FILE: sim/tb_packet_protocol_port_byte_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_protocol_port_byte_counter
// Drives Ethernet/IPv4 frames byte by byte into the port and protocol byte
// counter, with counter reads mixed in, and checks every frame report and read
// reply against a behavioural model of the counters kept in a scoreboard.
// Both handshakes idle at random; the port threshold is changed between phases.
// ----------------------------------------------------------------------------

module tb_packet_protocol_port_byte_counter;

  // The RAM clearing pass after reset is the longest quiet spell
  localparam int unsigned WatchdogCycles = 300000;
  localparam int unsigned HoldOffCycles  = 500;
  localparam int unsigned DrainCycles    = 8;

  typedef enum int {
    FrTcp, FrUdp, FrIcmp, FrOtherProto, FrLowIhl, FrBadOffset,
    FrCutIp, FrCutTcp, FrCutUdp, FrNoise, FrHuge
  } frame_kind_e;

  typedef struct {
    ppbc_pkg::reply_kind_e         kind;
    ppbc_pkg::proto_class_e        cls;
    ppbc_pkg::status_e             st;
    logic [15:0]                   port;
    logic [ppbc_pkg::CntWidth-1:0] value;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame being parsed and all counters, and keeps the
  // replies still owed by the block in order.
  // --------------------------------------------------------------------------
  class port_traffic_scoreboard;
    reply_t                        owed_q[$];
    int unsigned                   errors;
    logic [15:0]                   threshold;
    int unsigned                   byte_pos;
    int unsigned                   ihl_bytes;
    logic [7:0]                    proto;
    logic [15:0]                   source_port;
    logic [15:0]                   dest_port;
    logic [3:0]                    tcp_off;
    logic [ppbc_pkg::CntWidth-1:0] proto_bytes [ppbc_pkg::NumProtocols];
    logic [ppbc_pkg::CntWidth-1:0] port_bytes [int unsigned];

    function new();
      threshold = ppbc_pkg::ThresholdReset;
      errors    = 0;
      foreach (proto_bytes[i]) proto_bytes[i] = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos    = 0;
      ihl_bytes   = 0;
      proto       = '0;
      source_port = '0;
      dest_port   = '0;
      tcp_off     = '0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Update the model with one accepted input transaction.
    function void note_input(ppbc_pkg::cmd_e cmd, logic [7:0] b, logic last,
                             logic [15:0] wl, logic [15:0] idx);
      int unsigned pos;
      int unsigned t;
      int unsigned ipend;
      int unsigned p;
      reply_t      r;
      r.kind  = ppbc_pkg::KindRead;
      r.cls   = ppbc_pkg::ClsOther;
      r.st    = ppbc_pkg::StNothing;
      r.port  = '0;
      r.value = '0;
      case (cmd)
        ppbc_pkg::CmdByte: begin
          // Header capture for the byte at the current position
          pos = byte_pos;
          if (pos == ppbc_pkg::EthHdrBytes) begin
            ihl_bytes = b[3:0] * 4;
          end else if (pos == ppbc_pkg::EthHdrBytes + ppbc_pkg::IpProtoOffset) begin
            proto = b;
          end
          if (ihl_bytes >= ppbc_pkg::MinIhlBytes &&
              pos >= ppbc_pkg::EthHdrBytes + ihl_bytes) begin
            t = pos - ppbc_pkg::EthHdrBytes - ihl_bytes;
            case (t)
              0:                       source_port[15:8] = b;
              1:                       source_port[7:0]  = b;
              2:                       dest_port[15:8]   = b;
              3:                       dest_port[7:0]    = b;
              ppbc_pkg::TcpOffsetByte: tcp_off           = b[7:4];
              default: ;
            endcase
          end
          byte_pos = (pos < 16'hFFFF) ? pos + 1 : 16'hFFFF;
          if (!last) return;

          // End of frame: classify and update the counters
          r.kind = ppbc_pkg::KindFrame;
          ipend  = ppbc_pkg::EthHdrBytes + ihl_bytes;
          if (ihl_bytes >= ppbc_pkg::MinIhlBytes && byte_pos >= ipend) begin
            if (proto == ppbc_pkg::ProtoTcp &&
                byte_pos >= ipend + ppbc_pkg::TcpMinBytes) begin
              r.cls = ppbc_pkg::ClsTcp;
              r.st  = (tcp_off < ppbc_pkg::MinTcpOffset) ? ppbc_pkg::StBadOffset :
                                                            ppbc_pkg::StPortCounted;
            end else if (proto == ppbc_pkg::ProtoUdp &&
                         byte_pos >= ipend + ppbc_pkg::UdpMinBytes) begin
              r.cls = ppbc_pkg::ClsUdp;
              r.st  = ppbc_pkg::StPortCounted;
            end else if (proto == ppbc_pkg::ProtoIcmp) begin
              r.cls = ppbc_pkg::ClsIcmp;
              r.st  = ppbc_pkg::StProtoOnly;
            end
            if (r.cls != ppbc_pkg::ClsOther) begin
              proto_bytes[r.cls] = proto_bytes[r.cls] + wl;
            end
            if (r.st == ppbc_pkg::StPortCounted) begin
              r.port = (dest_port > threshold) ? source_port : dest_port;
              p = r.port;
              port_bytes[p] = (port_bytes.exists(p) ? port_bytes[p] : '0) + wl;
            end
          end
          clear_frame();
          owed_q.push_back(r);
        end
        ppbc_pkg::CmdReadProto: begin
          if (idx < ppbc_pkg::NumProtocols) r.value = proto_bytes[idx];
          owed_q.push_back(r);
        end
        ppbc_pkg::CmdReadPort: begin
          p = idx;
          if (port_bytes.exists(p)) r.value = port_bytes[p];
          owed_q.push_back(r);
        end
        default: ;  // command 3 is ignored by the block
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest owed reply.
    function void check_result(logic kind, logic [1:0] cls, logic [1:0] st,
                               logic [15:0] port, logic [63:0] value);
      reply_t r;
      if (owed_q.size() == 0) begin
        $error("result transaction arrived with no reply owed");
        errors++;
        return;
      end
      r = owed_q.pop_front();
      compare_field("reply_kind", r.kind, kind);
      compare_field("protocol_class", r.cls, cls);
      compare_field("status", r.st, st);
      compare_field("counted_port", r.port, port);
      compare_field("read_value", r.value, value);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [15:0] cfg_wr_data_i = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i     = '0;
  logic [7:0]  data_byte_i   = '0;
  logic        last_byte_i   = 1'b0;
  logic [15:0] wire_length_i = '0;
  logic [15:0] read_index_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b1;
  logic        reply_kind_o;
  logic [1:0]  protocol_class_o;
  logic [1:0]  status_o;
  logic [15:0] counted_port_o;
  logic [63:0] read_value_o;

  port_traffic_scoreboard sb = new();
  int unsigned            items_sent = 0;
  int unsigned            idle_cycles = 0;
  bit                     hold_out = 1'b0;
  bit                     no_idle = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  packet_protocol_port_byte_counter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .wire_length_i    (wire_length_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reply_kind_o     (reply_kind_o),
    .protocol_class_o (protocol_class_o),
    .status_o         (status_o),
    .counted_port_o   (counted_port_o),
    .read_value_o     (read_value_o)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Ports drawn from a small pool so that counters build up and reads hit them.
  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 8))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd80;
      3:       return 16'd443;
      4:       return 16'd9999;
      5:       return 16'd10000;
      6:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one transaction, with an optional idle gap in front of it
  // --------------------------------------------------------------------------
  task automatic send_item(input ppbc_pkg::cmd_e cmd, input logic [7:0] b,
                           input logic last, input logic [15:0] wl,
                           input logic [15:0] idx);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i     <= cmd;
    data_byte_i   <= b;
    last_byte_i   <= last;
    wire_length_i <= wl;
    read_index_i  <= idx;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, b, last, wl, idx);
    items_sent++;
    @(negedge clk_i);
  endtask

  // A counter read, or now and then an ignored command.
  task automatic send_query();
    int unsigned sel;
    logic [15:0] idx;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      idx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      send_item(ppbc_pkg::CmdReadProto, 8'($urandom), 1'($urandom), 16'($urandom), idx);
    end else if (sel < 9) begin
      send_item(ppbc_pkg::CmdReadPort, 8'($urandom), 1'($urandom), 16'($urandom),
                pick_port());
    end else begin
      send_item(ppbc_pkg::CmdNone, 8'($urandom), 1'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  // Build one frame of the given kind on the fly and send it byte by byte,
  // with an occasional read slipped in between the bytes.
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  known [3] = '{ppbc_pkg::ProtoTcp, ppbc_pkg::ProtoUdp,
                               ppbc_pkg::ProtoIcmp};
    int unsigned ihl;
    int unsigned ip_hdr;
    int unsigned tp_len;
    int unsigned total;
    int unsigned i;
    logic [7:0]  proto;
    logic [7:0]  b;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] wl;
    logic [3:0]  off;
    ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    src   = pick_port();
    dst   = pick_port();
    off   = 4'($urandom_range(ppbc_pkg::MinTcpOffset, 15));
    proto = ppbc_pkg::ProtoTcp;
    case (kind)
      FrTcp:       tp_len = ppbc_pkg::TcpMinBytes + $urandom_range(0, 20);
      FrUdp: begin
        proto  = ppbc_pkg::ProtoUdp;
        tp_len = ppbc_pkg::UdpMinBytes + $urandom_range(0, 20);
      end
      FrIcmp: begin
        proto  = ppbc_pkg::ProtoIcmp;
        tp_len = $urandom_range(0, 20);
      end
      FrOtherProto: begin
        do proto = 8'($urandom);
        while (proto == ppbc_pkg::ProtoTcp || proto == ppbc_pkg::ProtoUdp ||
               proto == ppbc_pkg::ProtoIcmp);
        tp_len = $urandom_range(0, 30);
      end
      FrLowIhl: begin
        ihl    = $urandom_range(0, 4);
        proto  = known[$urandom_range(0, 2)];
        tp_len = $urandom_range(0, 30);
      end
      FrBadOffset: begin
        off    = 4'($urandom_range(0, ppbc_pkg::MinTcpOffset - 1));
        tp_len = ppbc_pkg::TcpMinBytes + $urandom_range(0, 10);
      end
      FrCutTcp:    tp_len = $urandom_range(0, ppbc_pkg::TcpMinBytes - 1);
      FrCutUdp: begin
        proto  = ppbc_pkg::ProtoUdp;
        tp_len = $urandom_range(0, ppbc_pkg::UdpMinBytes - 1);
      end
      default:     tp_len = $urandom_range(0, 20);
    endcase
    ip_hdr = (ihl < 5) ? ppbc_pkg::MinIhlBytes : ihl * 4;
    total  = ppbc_pkg::EthHdrBytes + ip_hdr + tp_len;
    case (kind)
      FrCutIp: begin
        proto = known[$urandom_range(0, 2)];
        total = $urandom_range(1, ppbc_pkg::EthHdrBytes + ip_hdr - 1);
      end
      FrNoise: total = $urandom_range(1, 80);
      FrHuge:  total = 65540;  // runs past the saturation of the byte position
      default: ;
    endcase

    for (i = 0; i < total; i++) begin
      b = 8'($urandom);
      if (kind != FrNoise) begin
        if (i == ppbc_pkg::EthHdrBytes) begin
          b[3:0] = ihl[3:0];
        end else if (i == ppbc_pkg::EthHdrBytes + ppbc_pkg::IpProtoOffset) begin
          b = proto;
        end else if (i >= ppbc_pkg::EthHdrBytes + ip_hdr) begin
          case (i - ppbc_pkg::EthHdrBytes - ip_hdr)
            0:                       b      = src[15:8];
            1:                       b      = src[7:0];
            2:                       b      = dst[15:8];
            3:                       b      = dst[7:0];
            ppbc_pkg::TcpOffsetByte: b[7:4] = off;
            default: ;
          endcase
        end
      end
      case ($urandom_range(0, 9))
        0:       wl = 16'h0000;
        1:       wl = 16'hFFFF;
        default: wl = 16'($urandom);
      endcase
      if ($urandom_range(0, 15) == 0) send_query();
      send_item(ppbc_pkg::CmdByte, b, i == total - 1, wl, 16'($urandom));
    end
  endtask

  // Mixed traffic, mostly well-formed frames, until n more transactions are in.
  task automatic run_traffic(input int unsigned n);
    int unsigned start;
    int unsigned r;
    frame_kind_e kind;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 3) == 0) begin
        send_query();
      end else begin
        r = $urandom_range(0, 19);
        if (r < 6)       kind = FrTcp;
        else if (r < 10) kind = FrUdp;
        else if (r < 12) kind = FrIcmp;
        else if (r < 18) kind = frame_kind_e'(FrOtherProto + (r - 12));
        else             kind = FrNoise;
        send_frame(kind);
      end
    end
  endtask

  // Stop offering input and wait until every owed reply has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [15:0] value);
    wait_drained();
    cfg_wr_data_i <= value;
    cfg_wr_en_i   <= 1'b1;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.threshold = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_out = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len()) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each accepted result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(reply_kind_o, protocol_class_o, status_o, counted_port_o,
                      read_value_o);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty counters, out-of-range indexes, ignored command, tiny frames
    send_item(ppbc_pkg::CmdReadProto, 8'h00, 1'b0, 16'h0000, 16'd0);
    send_item(ppbc_pkg::CmdReadProto, 8'hFF, 1'b1, 16'hFFFF, 16'd1);
    send_item(ppbc_pkg::CmdReadProto, 8'h00, 1'b0, 16'h0000, 16'd2);
    send_item(ppbc_pkg::CmdReadProto, 8'hFF, 1'b1, 16'hFFFF, 16'd3);
    send_item(ppbc_pkg::CmdReadProto, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
    send_item(ppbc_pkg::CmdReadPort, 8'hFF, 1'b1, 16'hFFFF, 16'h0000);
    send_item(ppbc_pkg::CmdReadPort, 8'h00, 1'b0, 16'h0000, 16'hFFFF);
    send_item(ppbc_pkg::CmdNone, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    send_item(ppbc_pkg::CmdByte, 8'hFF, 1'b1, 16'hFFFF, 16'h0000);
    send_item(ppbc_pkg::CmdByte, 8'h00, 1'b0, 16'h1234, 16'hFFFF);
    send_item(ppbc_pkg::CmdByte, 8'h00, 1'b1, 16'h0000, 16'h0000);

    // One frame of every kind but FrHuge under the reset threshold, then mixed traffic
    for (int k = FrTcp; k < FrHuge; k++) send_frame(frame_kind_e'(k));
    run_traffic(250);

    set_threshold(16'h0000);
    run_traffic(300);

    // Results pile up behind a long receiver hold-off while input continues
    set_threshold(16'hFFFF);
    hold_out = 1'b1;
    run_traffic(300);

    // Back-to-back stretch with no idling on either side
    set_threshold(16'd443);
    no_idle = 1'b1;
    run_traffic(250);
    no_idle = 1'b0;

    set_threshold(16'($urandom));
    run_traffic(220);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
